// File: src/blpw_pkg.sv
// Shared types and constants for the Bresenham line pixel writer.
// Used by the channel interfaces, controller, datapath, top level and checker.
package blpw_pkg;

  localparam int unsigned COORD_W  = 6;
  localparam int unsigned SIDE_W   = 7;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IX_W = 2;
  localparam int unsigned ERR_W    = 9;

  // Largest screen side; register values above this saturate to it.
  localparam logic [SIDE_W-1:0] MAX_SIDE = 7'd64;

  localparam logic [CFG_IX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // capture a new line command
    logic step;   // emit the current point and advance the walk
  } ctl_t;

  // Datapath -> controller
  typedef struct packed {
    logic done;      // current point is the second endpoint
    logic out_free;  // output register can take a beat this cycle
  } stat_t;

endpackage

// File: src/blpw_cmd_if.sv
// Line command channel: valid/ready handshake plus the command fields.
// Depends on blpw_pkg for field widths.
interface blpw_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [blpw_pkg::COORD_W-1:0]     start_x;
  logic [blpw_pkg::COORD_W-1:0]     start_y;
  logic [blpw_pkg::COORD_W-1:0]     end_x;
  logic [blpw_pkg::COORD_W-1:0]     end_y;
  logic [blpw_pkg::BYTE_W-1:0]      glyph;
  logic [blpw_pkg::BYTE_W-1:0]      fore_colour;
  logic [blpw_pkg::BYTE_W-1:0]      back_colour;

  modport source (
    output valid, start_x, start_y, end_x, end_y, glyph, fore_colour, back_colour,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, glyph, fore_colour, back_colour,
    output ready
  );
endinterface

// File: src/blpw_pix_if.sv
// Pixel write channel: valid/ready handshake plus the pixel write fields.
// Depends on blpw_pkg for field widths.
interface blpw_pix_if;
  logic                             valid;
  logic                             ready;
  logic [blpw_pkg::COORD_W-1:0]     pix_col;
  logic [blpw_pkg::COORD_W-1:0]     pix_row;
  logic [blpw_pkg::ADDR_W-1:0]      buffer_addr;
  logic [blpw_pkg::BYTE_W-1:0]      char_code;
  logic [blpw_pkg::BYTE_W-1:0]      attribute;
  logic                             last;

  modport source (
    output valid, pix_col, pix_row, buffer_addr, char_code, attribute, last,
    input  ready
  );
  modport sink (
    input  valid, pix_col, pix_row, buffer_addr, char_code, attribute, last,
    output ready
  );
endinterface

// File: src/blpw_ctrl.sv
// Line walk controller: accepts a command, then steps the datapath once per
// free output slot until the second endpoint is written. Depends on blpw_pkg.
module blpw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  blpw_pkg::stat_t  stat,
  output blpw_pkg::ctl_t   ctl
);

  blpw_pkg::state_t state_r;
  blpw_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blpw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ctl       = '0;
    unique case (state_r)
      blpw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = blpw_pkg::ST_RUN;
        end
      end
      blpw_pkg::ST_RUN: begin
        if (stat.out_free) begin
          ctl.step = 1'b1;
          if (stat.done) begin
            state_nxt = blpw_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = blpw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/blpw_dp.sv
// Line walk datapath: screen size registers, Bresenham error walk, clamp,
// address multiply and the output register. Depends on blpw_pkg.
module blpw_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [blpw_pkg::CFG_IX_W-1:0]     cfg_index,
  input  logic [blpw_pkg::SIDE_W-1:0]       cfg_wdata,
  // command fields
  input  logic [blpw_pkg::COORD_W-1:0]      start_x,
  input  logic [blpw_pkg::COORD_W-1:0]      start_y,
  input  logic [blpw_pkg::COORD_W-1:0]      end_x,
  input  logic [blpw_pkg::COORD_W-1:0]      end_y,
  input  logic [blpw_pkg::BYTE_W-1:0]       glyph,
  input  logic [blpw_pkg::BYTE_W-1:0]       fore_colour,
  input  logic [blpw_pkg::BYTE_W-1:0]       back_colour,
  // control
  input  blpw_pkg::ctl_t                    ctl,
  output blpw_pkg::stat_t                   stat,
  // pixel write output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [blpw_pkg::COORD_W-1:0]      pix_col,
  output logic [blpw_pkg::COORD_W-1:0]      pix_row,
  output logic [blpw_pkg::ADDR_W-1:0]       buffer_addr,
  output logic [blpw_pkg::BYTE_W-1:0]       char_code,
  output logic [blpw_pkg::BYTE_W-1:0]       attribute,
  output logic                              last
);

  localparam int unsigned CW   = blpw_pkg::COORD_W;
  localparam int unsigned SW   = blpw_pkg::SIDE_W;
  localparam int unsigned EW   = blpw_pkg::ERR_W;
  localparam int unsigned PW   = CW + SW;

  // configuration registers
  logic [SW-1:0] width_r;
  logic [SW-1:0] height_r;

  // walk state
  logic [CW-1:0]        cx_r, cy_r, tx_r, ty_r;
  logic [CW-1:0]        adx_r, ady_r;
  logic                 sx_r, sy_r;     // 1: step up, 0: step down
  logic signed [EW-1:0] err_r;
  logic [blpw_pkg::BYTE_W-1:0] glyph_r, attr_r;

  // output register
  logic                        out_valid_r;
  logic [CW-1:0]               col_r, row_r;
  logic [blpw_pkg::ADDR_W-1:0] addr_r;
  logic [blpw_pkg::BYTE_W-1:0] code_r, attrib_r;
  logic                        last_r;

  logic [SW-1:0]        w_eff, h_eff;
  logic [CW-1:0]        px, py;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        addr_full;
  logic                 done;
  logic signed [EW:0]   e2;
  logic signed [EW:0]   e2_plus_ady;
  logic                 step_x, step_y;
  logic signed [EW-1:0] err_nxt;
  logic [CW-1:0]        adx_ld, ady_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= blpw_pkg::MAX_SIDE;
      height_r <= blpw_pkg::MAX_SIDE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        blpw_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        blpw_pkg::CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (width_r == '0) begin
      w_eff = SW'(1);
    end else if (width_r > blpw_pkg::MAX_SIDE) begin
      w_eff = blpw_pkg::MAX_SIDE;
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = SW'(1);
    end else if (height_r > blpw_pkg::MAX_SIDE) begin
      h_eff = blpw_pkg::MAX_SIDE;
    end else begin
      h_eff = height_r;
    end
  end

  always_comb begin
    px = ({1'b0, cx_r} >= w_eff) ? CW'(w_eff - SW'(1)) : cx_r;
    py = ({1'b0, cy_r} >= h_eff) ? CW'(h_eff - SW'(1)) : cy_r;
    prod      = PW'(py) * PW'(w_eff);
    addr_full = prod + PW'(px);
    done      = (cx_r == tx_r) && (cy_r == ty_r);
  end

  // e2 = 2*err; x moves when e2 >= -ady, y moves when e2 <= adx
  always_comb begin
    e2          = {err_r, 1'b0};
    e2_plus_ady = e2 + $signed({{(EW+1-CW){1'b0}}, ady_r});
    step_x      = !e2_plus_ady[EW];
    step_y      = e2 <= $signed({{(EW+1-CW){1'b0}}, adx_r});
    err_nxt     = err_r
                - (step_x ? $signed({{(EW-CW){1'b0}}, ady_r}) : EW'(0))
                + (step_y ? $signed({{(EW-CW){1'b0}}, adx_r}) : EW'(0));
    adx_ld      = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
    ady_ld      = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cx_r    <= start_x;
      cy_r    <= start_y;
      tx_r    <= end_x;
      ty_r    <= end_y;
      adx_r   <= adx_ld;
      ady_r   <= ady_ld;
      sx_r    <= start_x < end_x;
      sy_r    <= start_y < end_y;
      err_r   <= $signed({{(EW-CW){1'b0}}, adx_ld}) - $signed({{(EW-CW){1'b0}}, ady_ld});
      glyph_r <= glyph;
      attr_r  <= fore_colour | back_colour;
    end else if (ctl.step) begin
      err_r <= err_nxt;
      if (step_x) begin
        cx_r <= sx_r ? cx_r + CW'(1) : cx_r - CW'(1);
      end
      if (step_y) begin
        cy_r <= sy_r ? cy_r + CW'(1) : cy_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      col_r    <= px;
      row_r    <= py;
      addr_r   <= addr_full[blpw_pkg::ADDR_W-1:0];
      code_r   <= glyph_r;
      attrib_r <= attr_r;
      last_r   <= done;
    end
  end

  assign stat.done     = done;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign pix_col     = col_r;
  assign pix_row     = row_r;
  assign buffer_addr = addr_r;
  assign char_code   = code_r;
  assign attribute   = attrib_r;
  assign last        = last_r;

endmodule

// File: src/bresenham_line_pixel_writer_core.sv
// Bresenham line pixel writer. Each command on in_cmd draws one line and
// yields max(|dx|,|dy|)+1 pixel writes (1 to 64) on out_pix, the last one
// flagged. The walk unit produces one point per cycle into a single output
// register while out_pix is not stalled; a stall on out_pix holds the walk. A
// command is loaded before its first point is produced. The next command is
// taken as soon as the last point sits in the output register. screen_width
// (index 0) and screen_height (index 1) reset to 64; the user must write them
// through cfg_* between commands only, as the block does not enforce this.
module bresenham_line_pixel_writer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [blpw_pkg::CFG_IX_W-1:0]   cfg_index,
  input  logic [blpw_pkg::SIDE_W-1:0]     cfg_wdata,
  blpw_cmd_if.sink                        in_cmd,
  blpw_pix_if.source                      out_pix
);

  blpw_pkg::ctl_t  ctl;
  blpw_pkg::stat_t stat;

  blpw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_cmd.valid),
    .in_ready (in_cmd.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  blpw_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .start_x     (in_cmd.start_x),
    .start_y     (in_cmd.start_y),
    .end_x       (in_cmd.end_x),
    .end_y       (in_cmd.end_y),
    .glyph       (in_cmd.glyph),
    .fore_colour (in_cmd.fore_colour),
    .back_colour (in_cmd.back_colour),
    .ctl         (ctl),
    .stat        (stat),
    .out_valid   (out_pix.valid),
    .out_ready   (out_pix.ready),
    .pix_col     (out_pix.pix_col),
    .pix_row     (out_pix.pix_row),
    .buffer_addr (out_pix.buffer_addr),
    .char_code   (out_pix.char_code),
    .attribute   (out_pix.attribute),
    .last        (out_pix.last)
  );

endmodule

// File: src/blpw_checker.sv
// Port-level checks for the line pixel writer, bound to the top level.
// Depends on blpw_pkg for field widths.
module blpw_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [blpw_pkg::ADDR_W-1:0]   buffer_addr,
  input  logic                          last
);

  // a held beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(buffer_addr) && $stable(last))
    else $error("out beat changed while stalled");

  // an accepted command closes the command port as its line starts
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while a line was starting");

  // a non-final beat waiting in the output means the line is still running
  a_busy_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> !in_ready)
    else $error("command port open in the middle of a line");

endmodule

bind bresenham_line_pixel_writer_core blpw_checker u_blpw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_cmd.valid),
  .in_ready    (in_cmd.ready),
  .out_valid   (out_pix.valid),
  .out_ready   (out_pix.ready),
  .buffer_addr (out_pix.buffer_addr),
  .last        (out_pix.last)
);
